### rtl/ptd_pkg.sv
// Shared constants for the trial-division primality tester.
// No dependencies; imported by ptd_divider and prime_test_trial_division_top.
package ptd_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FIRST_DIVISOR  = 5;
   localparam int WHEEL_STEP     = 6;
   localparam int PAIR_OFFSET    = 2;
   localparam int SMALL_PRIME_A  = 2;
   localparam int SMALL_PRIME_B  = 3;

endpackage

### rtl/ptd_divider.sv
// Bit-serial restoring divider that returns the remainder only.
// One quotient bit per cycle. Uses ptd_pkg.
module ptd_divider #(
   parameter int DATA_WIDTH = ptd_pkg::DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DATA_WIDTH-1:0] dividend,
   input  logic [DATA_WIDTH-1:0] divisor,
   output logic                  done,
   output logic [DATA_WIDTH-1:0] remainder
);
   import ptd_pkg::*;

   localparam int CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] dvd_ff, dvd_in;
   logic [DATA_WIDTH-1:0] dsr_ff, dsr_in;
   logic [DATA_WIDTH:0]   trial;

   assign trial = {rem_ff, dvd_ff[DATA_WIDTH-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = DATA_WIDTH'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = trial[DATA_WIDTH-1:0];
         end
         dvd_in = {dvd_ff[DATA_WIDTH-2:0], 1'b0};
         cnt_in = CNT_W'(cnt_ff + 1'b1);
         if (cnt_ff == CNT_W'(DATA_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

### rtl/prime_test_trial_division_top.sv
// Trial-division primality tester, 6k+/-1 wheel, one signed number per transfer.
// An item needs no division when it is at most 3, negative or zero; otherwise
// each trial divisor (2, 3, then d and d+2 for d = 5, 11, 17, ... while d*d <= n)
// runs on the shared bit-serial remainder unit, with one square check per pair.
// A 32-bit prime near 2^31 needs about 15,500 divisions. One item is in work at
// a time; the result register lets the next item enter while a result waits to
// be taken.
// Depends on ptd_pkg and ptd_divider.
module prime_test_trial_division_top #(
   parameter int DATA_WIDTH = ptd_pkg::DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_number,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_prime
);
   import ptd_pkg::*;

   localparam int SQ_W = DATA_WIDTH + 2;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIV    = 4'b0010,
      ST_SQCHK  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   typedef enum logic [3:0] {
      PH_TRY2  = 4'b0001,
      PH_TRY3  = 4'b0010,
      PH_TRYD  = 4'b0100,
      PH_TRYD2 = 4'b1000
   } phase_type;

   state_type             state_ff, state_in;
   phase_type             phase_ff, phase_in;
   logic [DATA_WIDTH-1:0] n_ff, n_in;
   logic [DATA_WIDTH-1:0] d_ff, d_in;
   logic [SQ_W-1:0]       sq_ff, sq_in;
   logic                  result_ff, result_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_prime_ff, rsp_prime_in;

   logic                  div_start;
   logic [DATA_WIDTH-1:0] div_divisor;
   logic                  div_done;
   logic [DATA_WIDTH-1:0] div_rem;
   logic [DATA_WIDTH-1:0] num_u;
   logic                  req_xfer;
   logic                  rsp_free;
   logic [SQ_W-1:0]       sq_step;

   assign num_u     = DATA_WIDTH'(unsigned'(req_number));
   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign sq_step   = SQ_W'(SQ_W'(2 * WHEEL_STEP) * SQ_W'(d_ff))
                    + SQ_W'(WHEEL_STEP * WHEEL_STEP);

   ptd_divider #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (n_in),
      .divisor   (div_divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      sq_in        = sq_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_prime_in = rsp_prime_ff;
      div_start    = 1'b0;
      div_divisor  = DATA_WIDTH'(SMALL_PRIME_A);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               n_in = num_u;
               if (num_u[DATA_WIDTH-1] || num_u <= DATA_WIDTH'(1)) begin
                  result_in = 1'b0;
                  state_in  = ST_FINISH;
               end else if (num_u <= DATA_WIDTH'(SMALL_PRIME_B)) begin
                  result_in = 1'b1;
                  state_in  = ST_FINISH;
               end else begin
                  phase_in = PH_TRY2;
                  state_in = ST_DIV;
                  div_start = 1'b1;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (div_rem == '0) begin
                  result_in = 1'b0;
                  state_in  = ST_FINISH;
               end else begin
                  unique case (phase_ff)
                     PH_TRY2: begin
                        div_start   = 1'b1;
                        div_divisor = DATA_WIDTH'(SMALL_PRIME_B);
                        phase_in    = PH_TRY3;
                     end
                     PH_TRY3: begin
                        d_in     = DATA_WIDTH'(FIRST_DIVISOR);
                        sq_in    = SQ_W'(FIRST_DIVISOR * FIRST_DIVISOR);
                        state_in = ST_SQCHK;
                     end
                     PH_TRYD: begin
                        div_start   = 1'b1;
                        div_divisor = DATA_WIDTH'(d_ff + DATA_WIDTH'(PAIR_OFFSET));
                        phase_in    = PH_TRYD2;
                     end
                     PH_TRYD2: begin
                        d_in     = DATA_WIDTH'(d_ff + DATA_WIDTH'(WHEEL_STEP));
                        sq_in    = SQ_W'(sq_ff + sq_step);
                        state_in = ST_SQCHK;
                     end
                     default: begin
                        state_in = ST_IDLE;
                     end
                  endcase
               end
            end
         end
         ST_SQCHK: begin
            if (sq_ff > SQ_W'(n_ff)) begin
               result_in = 1'b1;
               state_in  = ST_FINISH;
            end else begin
               div_start   = 1'b1;
               div_divisor = d_ff;
               phase_in    = PH_TRYD;
               state_in    = ST_DIV;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_TRY2;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff         <= n_in;
      d_ff         <= d_in;
      sq_ff        <= sq_in;
      result_ff    <= result_in;
      rsp_prime_ff <= rsp_prime_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_prime = rsp_prime_ff;

endmodule
